@@ src/drti_pkg.sv @@
// Package for the double round-to-integral unit.
// Holds the rounding command codes and the shared stage payload types.
// No dependencies.
package drti_pkg;

  localparam logic [10:0] ExpBias = 11'd1023;
  localparam logic [10:0] ExpBig = 11'd1075;
  localparam logic [63:0] OneBits = 64'h3FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_TRUNC = 2'd0,
    CMD_FLOOR = 2'd1,
    CMD_CEIL  = 2'd2,
    CMD_ROUND = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [63:0] value;
    logic        pass;
    logic        sub_one;
    logic        small_one;
    logic [63:0] mask;
    logic [63:0] half;
    logic        up_fixed;
    logic        round_mode;
  } s1_t;

  typedef struct packed {
    logic [63:0] value;
    logic        pass;
    logic        sub_one;
    logic        small_one;
    logic        exact;
    logic        up;
    logic [63:0] whole;
    logic [63:0] inc;
  } s2_t;

endpackage

@@ src/double_round_to_integral_unit.sv @@
// Top level of the double round-to-integral unit: stream ports around the core.
// Depends on drti_pkg and drti_core.
//
// Channel | Direction | tdata                         | tuser
// in      | request   | [63:0] value                  | [1:0] command
// out     | result    | [63:0] rounded                | none
//
// One request is taken every cycle while the output is not stalled.
// The pipeline advances whenever its last stage is empty or being taken.
// A stall on the output holds all three stages in place.
// Synchronous active-low reset empties the pipeline.
module double_round_to_integral_unit
  import drti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] rounded
);

  logic en;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  drti_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .out_valid (out_tvalid),
    .out_value (out_tdata)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != 64'h8000_0000_0000_0000))
    else $error("Negative zero produced.");

endmodule

@@ src/drti_core.sv @@
// Three-stage datapath for round to integral: decode, mask and decide, add.
// Uses drti_pkg; stalls hold every stage through the enable input.
module drti_core
  import drti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [63:0] out_value
);

  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  logic        v1_r, v2_r, v3_r;
  logic [63:0] res_r, res_nxt;

  always_comb begin
    logic [10:0] e;
    logic        neg, nz;
    logic [5:0]  fb;
    cmd_t        c;
    e = in_value[62:52];
    neg = in_value[63];
    nz = |in_value[62:0];
    c = cmd_t'(in_cmd);
    fb = 6'(ExpBig - e);
    s1_nxt.value = in_value;
    s1_nxt.pass = (e >= ExpBig);
    s1_nxt.sub_one = (e < ExpBias);
    case (c)
      CMD_FLOOR: s1_nxt.small_one = neg && nz;
      CMD_CEIL:  s1_nxt.small_one = !neg && nz;
      CMD_ROUND: s1_nxt.small_one = (e == ExpBias - 11'd1);
      default:   s1_nxt.small_one = 1'b0;
    endcase
    s1_nxt.mask = (64'd1 << fb) - 64'd1;
    s1_nxt.half = 64'd1 << (fb - 6'd1);
    case (c)
      CMD_FLOOR: s1_nxt.up_fixed = neg;
      CMD_CEIL:  s1_nxt.up_fixed = !neg;
      default:   s1_nxt.up_fixed = 1'b0;
    endcase
    s1_nxt.round_mode = (c == CMD_ROUND);
  end

  always_comb begin
    s2_nxt.value = s1_r.value;
    s2_nxt.pass = s1_r.pass;
    s2_nxt.sub_one = s1_r.sub_one;
    s2_nxt.small_one = s1_r.small_one;
    s2_nxt.exact = ((s1_r.value & s1_r.mask) == 64'd0);
    s2_nxt.up = s1_r.round_mode ? |(s1_r.value & s1_r.half) : s1_r.up_fixed;
    s2_nxt.whole = s1_r.value & ~s1_r.mask;
    s2_nxt.inc = s1_r.mask + 64'd1;
  end

  always_comb begin
    if (s2_r.pass || (!s2_r.sub_one && s2_r.exact)) begin
      res_nxt = s2_r.value;
    end else if (s2_r.sub_one) begin
      res_nxt = s2_r.small_one ? ({s2_r.value[63], 63'd0} | OneBits) : 64'd0;
    end else begin
      res_nxt = s2_r.up ? s2_r.whole + s2_r.inc : s2_r.whole;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_value = res_r;

endmodule
